>>> design/tun_pkg.sv
package tun_pkg;

    // coordinate and fraction widths of the datapath
    localparam int CW  = 24;
    localparam int F   = 30;

    // derived widths
    localparam int EW  = CW + 1;        // edge vector component
    localparam int PW  = 2 * EW;        // edge product
    localparam int NW  = PW + 1;        // cross product component, signed
    localparam int MW  = NW;            // magnitude of a component, unsigned
    localparam int ML  = MW / 2;        // low half of magnitude split
    localparam int MH  = MW - ML;       // high half of magnitude split
    localparam int SQW = 2 * MW;        // squared magnitude
    localparam int SW  = SQW + 2;       // sum of three squares
    localparam int RW  = SW + 2 * F + 5;// residual and running product, signed
    localparam int QW  = F + 1;         // quotient, value at most 2^F
    localparam int OW  = 32;            // output component width

    // pipeline depth from request to result strobe
    localparam int LAT = F + 9;

    localparam int NCOMP = 3;

endpackage

>>> design/triangle_unit_normal.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------------------------
// request  | in        | start, busy        | i_a_*, i_b_*, i_c_*, i_last_triangle
// result   | out       | o_valid (strobe)   | o_normal_*, o_degenerate, o_last_out
//
// One request enters every cycle; busy is held low, the pipeline never blocks.
// Each result passes through the bit-per-stage quotient pipeline (F+1 stages)
// plus eight setup/output stages.
// Reset (i_rst_n low, synchronous) drops every request in flight.
// The receiver cannot stall: a result is on the ports for exactly one cycle.
module triangle_unit_normal (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [tun_pkg::CW-1:0] i_a_x,
    input  logic signed [tun_pkg::CW-1:0] i_a_y,
    input  logic signed [tun_pkg::CW-1:0] i_a_z,
    input  logic signed [tun_pkg::CW-1:0] i_b_x,
    input  logic signed [tun_pkg::CW-1:0] i_b_y,
    input  logic signed [tun_pkg::CW-1:0] i_b_z,
    input  logic signed [tun_pkg::CW-1:0] i_c_x,
    input  logic signed [tun_pkg::CW-1:0] i_c_y,
    input  logic signed [tun_pkg::CW-1:0] i_c_z,
    input  logic                          i_last_triangle,
    output logic                          o_valid,
    output logic signed [tun_pkg::OW-1:0] o_normal_x,
    output logic signed [tun_pkg::OW-1:0] o_normal_y,
    output logic signed [tun_pkg::OW-1:0] o_normal_z,
    output logic                          o_degenerate,
    output logic                          o_last_out
);

    localparam int EW  = tun_pkg::EW;
    localparam int PW  = tun_pkg::PW;
    localparam int NW  = tun_pkg::NW;
    localparam int MW  = tun_pkg::MW;
    localparam int ML  = tun_pkg::ML;
    localparam int MH  = tun_pkg::MH;
    localparam int SQW = tun_pkg::SQW;
    localparam int SW  = tun_pkg::SW;
    localparam int RW  = tun_pkg::RW;
    localparam int QW  = tun_pkg::QW;
    localparam int OW  = tun_pkg::OW;
    localparam int F   = tun_pkg::F;
    localparam int NC  = tun_pkg::NCOMP;

    // the pipeline never backs up
    assign busy = 1'b0;

    // ---------------- stage 1: edge vectors ----------------
    logic                 r1_vld, r1_last;
    logic signed [EW-1:0] r1_e1x, r1_e1y, r1_e1z, r1_e2x, r1_e2y, r1_e2z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start & ~busy;
        end
        r1_last <= i_last_triangle;
        r1_e1x  <= EW'(i_b_x) - EW'(i_a_x);
        r1_e1y  <= EW'(i_b_y) - EW'(i_a_y);
        r1_e1z  <= EW'(i_b_z) - EW'(i_a_z);
        r1_e2x  <= EW'(i_c_x) - EW'(i_a_x);
        r1_e2y  <= EW'(i_c_y) - EW'(i_a_y);
        r1_e2z  <= EW'(i_c_z) - EW'(i_a_z);
    end

    // stage 2: edge products, a pair per cross component
    logic                 r2_vld, r2_last;
    logic signed [PW-1:0] r2_p [0:5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_last  <= r1_last;
        r2_p[0]  <= r1_e1y * r1_e2z;
        r2_p[1]  <= r1_e1z * r1_e2y;
        r2_p[2]  <= r1_e1z * r1_e2x;
        r2_p[3]  <= r1_e1x * r1_e2z;
        r2_p[4]  <= r1_e1x * r1_e2y;
        r2_p[5]  <= r1_e1y * r1_e2x;
    end

    // ---------------- stage 3: cross product, sign and magnitude ----------------
    logic signed [NW-1:0] n_cross [0:NC-1];
    logic                 r3_vld, r3_last, r3_deg;
    logic        [NC-1:0] r3_neg;
    logic        [MW-1:0] r3_mag [0:NC-1];

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            n_cross[c] = NW'(r2_p[2*c]) - NW'(r2_p[2*c+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_last <= r2_last;
        r3_deg  <= (n_cross[0] == '0) && (n_cross[1] == '0) && (n_cross[2] == '0);
        for (int c = 0; c < NC; c++) begin
            r3_neg[c] <= n_cross[c][NW-1];
            r3_mag[c] <= n_cross[c][NW-1] ? MW'(-n_cross[c]) : MW'(n_cross[c]);
        end
    end

    // ---------------- stage 4: partial products of the squares ----------------
    logic                  r4_vld, r4_last, r4_deg;
    logic         [NC-1:0] r4_neg;
    logic [2*MH-1:0]       r4_hh [0:NC-1];
    logic [MH+ML-1:0]      r4_hl [0:NC-1];
    logic [2*ML-1:0]       r4_ll [0:NC-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_last <= r3_last;
        r4_deg  <= r3_deg;
        r4_neg  <= r3_neg;
        for (int c = 0; c < NC; c++) begin
            r4_hh[c] <= r3_mag[c][MW-1:ML] * r3_mag[c][MW-1:ML];
            r4_hl[c] <= r3_mag[c][MW-1:ML] * r3_mag[c][ML-1:0];
            r4_ll[c] <= r3_mag[c][ML-1:0] * r3_mag[c][ML-1:0];
        end
    end

    // ---------------- stage 5: assemble the squares ----------------
    logic           r5_vld, r5_last, r5_deg;
    logic  [NC-1:0] r5_neg;
    logic [SQW-1:0] r5_sq [0:NC-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_last <= r4_last;
        r5_deg  <= r4_deg;
        r5_neg  <= r4_neg;
        for (int c = 0; c < NC; c++) begin
            r5_sq[c] <= (SQW'(r4_hh[c]) << (2 * ML)) + (SQW'(r4_hl[c]) << (ML + 1))
                      + SQW'(r4_ll[c]);
        end
    end

    // ---------------- stage 6: squared length ----------------
    logic           r6_vld, r6_last, r6_deg;
    logic  [NC-1:0] r6_neg;
    logic [SQW-1:0] r6_sq [0:NC-1];
    logic  [SW-1:0] r6_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
        r6_last <= r5_last;
        r6_deg  <= r5_deg;
        r6_neg  <= r5_neg;
        r6_sq   <= r5_sq;
        r6_s    <= SW'(r5_sq[0]) + SW'(r5_sq[1]) + SW'(r5_sq[2]);
    end

    // ---------------- quotient pipeline ----------------
    // Find the largest q with (2q-1)^2 * s <= m^2 * 2^(2F+2), one bit per stage.
    // rem holds m^2*2^(2F+2) - x^2*s and prd holds x*s, with x = 2q-1.
    // Trying bit k adds 2^(k+1) to x, which lowers rem by
    // prd*2^(k+2) + s*2^(2k+2) and raises prd by s*2^(k+1).
    logic                 r_it_vld  [0:F+1];
    logic                 r_it_last [0:F+1];
    logic                 r_it_deg  [0:F+1];
    logic        [NC-1:0] r_it_neg  [0:F+1];
    logic        [SW-1:0] r_it_s    [0:F+1];
    logic signed [RW-1:0] r_rem     [0:F+1][0:NC-1];
    logic signed [RW-1:0] r_prd     [0:F+1][0:NC-1];
    logic        [QW-1:0] r_q       [0:F+1][0:NC-1];

    // seed: q = 0, x = -1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it_vld[0] <= 1'b0;
        end else begin
            r_it_vld[0] <= r6_vld;
        end
        r_it_last[0] <= r6_last;
        r_it_deg[0]  <= r6_deg;
        r_it_neg[0]  <= r6_neg;
        r_it_s[0]    <= r6_s;
        for (int c = 0; c < NC; c++) begin
            r_rem[0][c] <= (RW'(r6_sq[c]) <<< (2 * F + 2)) - RW'(r6_s);
            r_prd[0][c] <= -RW'(r6_s);
            r_q[0][c]   <= '0;
        end
    end

    for (genvar j = 0; j <= F; j++) begin : g_bit
        localparam int K = F - j;

        logic signed [RW-1:0] s_ext;
        logic signed [RW-1:0] n_trial [0:NC-1];

        assign s_ext = RW'(r_it_s[j]);

        always_comb begin
            for (int c = 0; c < NC; c++) begin
                n_trial[c] = r_rem[j][c] - (r_prd[j][c] <<< (K + 2))
                           - (s_ext <<< (2 * K + 2));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_it_vld[j+1] <= 1'b0;
            end else begin
                r_it_vld[j+1] <= r_it_vld[j];
            end
            r_it_last[j+1] <= r_it_last[j];
            r_it_deg[j+1]  <= r_it_deg[j];
            r_it_neg[j+1]  <= r_it_neg[j];
            r_it_s[j+1]    <= r_it_s[j];
            for (int c = 0; c < NC; c++) begin
                if (!n_trial[c][RW-1]) begin
                    // keep the bit: condition still holds
                    r_rem[j+1][c] <= n_trial[c];
                    r_prd[j+1][c] <= r_prd[j][c] + (s_ext <<< (K + 1));
                    r_q[j+1][c]   <= r_q[j][c] | (QW'(1) << K);
                end else begin
                    // drop the bit
                    r_rem[j+1][c] <= r_rem[j][c];
                    r_prd[j+1][c] <= r_prd[j][c];
                    r_q[j+1][c]   <= r_q[j][c];
                end
            end
        end
    end

    // ---------------- output stage: sign and degenerate override ----------------
    logic signed [OW-1:0] n_out [0:NC-1];
    logic                 r_o_vld, r_o_last, r_o_deg;
    logic signed [OW-1:0] r_o_n [0:NC-1];

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            if (r_it_deg[F+1]) begin
                n_out[c] = '0;
            end else if (r_it_neg[F+1][c]) begin
                n_out[c] = -OW'(r_q[F+1][c]);
            end else begin
                n_out[c] = OW'(r_q[F+1][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_it_vld[F+1];
        end
        r_o_last <= r_it_last[F+1];
        r_o_deg  <= r_it_deg[F+1];
        r_o_n    <= n_out;
    end

    assign o_valid      = r_o_vld;
    assign o_normal_x   = r_o_n[0];
    assign o_normal_y   = r_o_n[1];
    assign o_normal_z   = r_o_n[2];
    assign o_degenerate = r_o_deg;
    assign o_last_out   = r_o_last;

`ifndef ASSERT_OFF
    // every accepted request yields its result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(tun_pkg::LAT) o_valid)
        else $error("result missing after pipeline latency");

    // a degenerate result carries a zero vector
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
            (o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0))
        else $error("degenerate result with nonzero normal");

    // components never exceed one in magnitude
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            (o_normal_x <= (OW'(1) <<< F) && o_normal_x >= -(OW'(1) <<< F) &&
             o_normal_y <= (OW'(1) <<< F) && o_normal_y >= -(OW'(1) <<< F) &&
             o_normal_z <= (OW'(1) <<< F) && o_normal_z >= -(OW'(1) <<< F)))
        else $error("normal component out of unit range");
`endif

endmodule

>>> tb/sv/triangle_unit_normal_tb.sv
`timescale 1ns / 100ps

module triangle_unit_normal_tb;

    localparam int CW  = tun_pkg::CW;
    localparam int OW  = tun_pkg::OW;
    localparam int F   = tun_pkg::F;
    localparam int LAT = tun_pkg::LAT;

    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_COUNT = 1530;

    // One triangle request as it goes onto the ports
    typedef struct {
        logic signed [CW-1:0] ax, ay, az;
        logic signed [CW-1:0] bx, by, bz;
        logic signed [CW-1:0] cx, cy, cz;
        logic                 last;
    } tri_req_t;

    // One unit normal as it should come back
    typedef struct {
        logic signed [OW-1:0] nx, ny, nz;
        logic                 degen;
        logic                 last;
    } normal_t;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [CW-1:0] i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic signed [CW-1:0] i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic signed [CW-1:0] i_c_x = '0, i_c_y = '0, i_c_z = '0;
    logic i_last_triangle = 1'b0;
    logic o_valid;
    logic signed [OW-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic o_degenerate, o_last_out;

    tri_req_t pending_tris[$];
    normal_t  expected_normals[$];
    tri_req_t on_ports;
    int       sent_count = 0;
    int       mismatch_count = 0;
    int       cycle_count = 0;

    triangle_unit_normal u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_a_x           (i_a_x),
        .i_a_y           (i_a_y),
        .i_a_z           (i_a_z),
        .i_b_x           (i_b_x),
        .i_b_y           (i_b_y),
        .i_b_z           (i_b_z),
        .i_c_x           (i_c_x),
        .i_c_y           (i_c_y),
        .i_c_z           (i_c_z),
        .i_last_triangle (i_last_triangle),
        .o_valid         (o_valid),
        .o_normal_x      (o_normal_x),
        .o_normal_y      (o_normal_y),
        .o_normal_z      (o_normal_z),
        .o_degenerate    (o_degenerate),
        .o_last_out      (o_last_out)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Round |n_k| / |n| * 2^F to nearest, ties away from zero: find the largest q
    // in [0, 2^F] with (2q-1)^2 * sumsq <= m^2 * 2^(2F+2). Keep everything exact.
    function automatic logic [63:0] scaled_magnitude(logic [63:0] m, logic [255:0] sumsq);
        logic [255:0] bound;
        logic [255:0] odd;
        logic [255:0] lhs;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        bound = {192'b0, m};
        bound = (bound * bound) << (2 * F + 2);
        lo = 0;
        hi = 64'd1 << F;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            odd = {192'b0, 2 * mid - 1};
            lhs = odd * odd * sumsq;
            if (lhs <= bound) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return lo;
    endfunction

    // Form the edges, the exact cross product, and the normalized result
    function automatic normal_t face_normal(tri_req_t t);
        normal_t      r;
        longint       e1x, e1y, e1z, e2x, e2y, e2z;
        longint       n[3];
        logic [63:0]  mag;
        logic [63:0]  q;
        logic [63:0]  v;
        logic [255:0] wide;
        logic [255:0] sumsq;
        logic [OW-1:0] comp[3];
        e1x = longint'(t.bx) - longint'(t.ax);
        e1y = longint'(t.by) - longint'(t.ay);
        e1z = longint'(t.bz) - longint'(t.az);
        e2x = longint'(t.cx) - longint'(t.ax);
        e2y = longint'(t.cy) - longint'(t.ay);
        e2z = longint'(t.cz) - longint'(t.az);
        n[0] = e1y * e2z - e1z * e2y;
        n[1] = e1z * e2x - e1x * e2z;
        n[2] = e1x * e2y - e1y * e2x;
        r.last = t.last;
        r.degen = (n[0] == 0 && n[1] == 0 && n[2] == 0);
        sumsq = '0;
        for (int k = 0; k < 3; k++) begin
            mag = (n[k] < 0) ? 64'(-n[k]) : 64'(n[k]);
            wide = {192'b0, mag};
            sumsq = sumsq + wide * wide;
        end
        for (int k = 0; k < 3; k++) begin
            comp[k] = '0;
            if (!r.degen) begin
                mag = (n[k] < 0) ? 64'(-n[k]) : 64'(n[k]);
                q = scaled_magnitude(mag, sumsq);
                v = (n[k] < 0) ? -q : q;
                comp[k] = v[OW-1:0];
            end
        end
        r.nx = comp[0];
        r.ny = comp[1];
        r.nz = comp[2];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [OW-1:0] got, logic [OW-1:0] want);
        mismatch_count++;
        $display("mismatch %s at cycle %0d: got %0h, want %0h", what, cycle_count, got, want);
    endtask

    function automatic logic signed [CW-1:0] any_coord();
        return CW'($urandom);
    endfunction

    function automatic logic signed [CW-1:0] near_coord(int span);
        return CW'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic logic any_last();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic add_tri(logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                           logic signed [CW-1:0] az, logic signed [CW-1:0] bx,
                           logic signed [CW-1:0] by, logic signed [CW-1:0] bz,
                           logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                           logic signed [CW-1:0] cz, logic last);
        tri_req_t t;
        t.ax = ax; t.ay = ay; t.az = az;
        t.bx = bx; t.by = by; t.bz = bz;
        t.cx = cx; t.cy = cy; t.cz = cz;
        t.last = last;
        pending_tris.push_back(t);
    endtask

    // Driver: advance on acceptance, then present the next request or idle.
    // Idle about 27 percent of cycles, except over a long calm stretch.
    always @(posedge i_clk) begin
        bit idle;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RESET_CYCLES) begin
            i_rst_n <= 1'b1;
        end
        if (start && !busy) begin
            expected_normals.push_back(face_normal(on_ports));
            sent_count++;
        end
        if (i_rst_n && (!start || !busy)) begin
            idle = ($urandom_range(0, 99) < 27) && !(sent_count > 600 && sent_count < 900);
            if (pending_tris.size() > 0 && !idle) begin
                on_ports = pending_tris.pop_front();
                i_a_x <= on_ports.ax; i_a_y <= on_ports.ay; i_a_z <= on_ports.az;
                i_b_x <= on_ports.bx; i_b_y <= on_ports.by; i_b_z <= on_ports.bz;
                i_c_x <= on_ports.cx; i_c_y <= on_ports.cy; i_c_z <= on_ports.cz;
                i_last_triangle <= on_ports.last;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("triangle_unit_normal_tb failed");
            $finish;
        end
    end

    // Monitor: take each strobed result and check it against the oldest expectation
    always @(posedge i_clk) begin
        normal_t want;
        if (i_rst_n && o_valid) begin
            if (expected_normals.size() == 0) begin
                report_mismatch("unexpected result", o_normal_x, '0);
            end else begin
                want = expected_normals.pop_front();
                if (o_normal_x !== want.nx) report_mismatch("normal_x", o_normal_x, want.nx);
                if (o_normal_y !== want.ny) report_mismatch("normal_y", o_normal_y, want.ny);
                if (o_normal_z !== want.nz) report_mismatch("normal_z", o_normal_z, want.nz);
                if (o_degenerate !== want.degen)
                    report_mismatch("degenerate", OW'(o_degenerate), OW'(want.degen));
                if (o_last_out !== want.last)
                    report_mismatch("last_out", OW'(o_last_out), OW'(want.last));
            end
        end
    end

    initial begin
        logic signed [CW-1:0] mx, mn;
        logic signed [CW-1:0] ax, ay, az, dx, dy, dz;
        int kind, k;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};

        // Directed: extremes, axis-aligned faces, degenerate shapes, batch marker
        add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b0);
        add_tri(0, 0, 0, 0, 1, 0, 1, 0, 0, 1'b1);
        add_tri(0, 0, 0, 0, 0, 1, 1, 0, 0, 1'b0);
        add_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn, 1'b0);
        add_tri(mx, mx, mx, mn, mx, mx, mx, mn, mx, 1'b1);
        add_tri(mn, mx, mn, mx, mn, mx, mx, mx, mn, 1'b0);
        add_tri(mx, mn, mx, mn, mn, mx, mn, mx, mn, 1'b0);
        add_tri(mn, mn, mn, mx, mx, mx, mn, mx, mx, 1'b1);
        add_tri(mn, mn, mn, mn, mn, mn, mn, mn, mn, 1'b0);  // coincident vertices
        add_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx, 1'b1);  // coincident at the top
        add_tri(0, 0, 0, 1, 1, 1, 2, 2, 2, 1'b0);           // collinear
        add_tri(mn, mn, mn, mx, mx, mx, mn, mn, mn, 1'b1);  // two equal, long edge
        add_tri(1, 2, 3, 1, 2, 3, 7, -4, 9, 1'b0);          // a equals b
        add_tri(0, 0, 0, 1, 1, 0, -1, 1, 0, 1'b0);          // equal x and y magnitudes
        add_tri(0, 0, 0, 1, 2, 0, 0, 0, 1, 1'b0);
        add_tri(0, 0, 0, 3, 0, 0, 0, 4, 0, 1'b1);
        add_tri(-1, -1, -1, -1, -1, 0, -1, 0, -1, 1'b0);
        add_tri(0, 0, 0, 1, -1, 1, 2, 1, -1, 1'b1);
        add_tri(mx, 0, mn, 0, mx, 0, mn, 0, mx, 1'b0);
        add_tri(-5, 7, 2, 13, -1, 4, 9, 9, -8, 1'b1);

        // Random: mostly full-range triangles, plus small and collinear ones
        // that reach the degenerate and rounding-tie corners
        for (int i = 0; i < RANDOM_COUNT; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                add_tri(any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
                        any_coord(), any_coord(), any_coord(), any_coord(), any_last());
            end else if (kind < 80) begin
                add_tri(near_coord(4), near_coord(4), near_coord(4), near_coord(4),
                        near_coord(4), near_coord(4), near_coord(4), near_coord(4),
                        near_coord(4), any_last());
            end else if (kind < 92) begin
                ax = near_coord(100000); ay = near_coord(100000); az = near_coord(100000);
                dx = near_coord(50);     dy = near_coord(50);     dz = near_coord(50);
                k  = $urandom_range(0, 200) - 100;
                add_tri(ax, ay, az, ax + dx, ay + dy, az + dz,
                        CW'(ax + k * dx), CW'(ay + k * dy), CW'(az + k * dz), any_last());
            end else begin
                // big offset, small triangle: tests wrap-free edge arithmetic
                ax = any_coord(); ay = any_coord(); az = any_coord();
                add_tri(ax, ay, az, ax + near_coord(3), ay + near_coord(3), az,
                        ax, ay + near_coord(3), az + near_coord(3), any_last());
            end
        end

        // Hold until every request is in and every result is back, then drain
        do begin
            @(posedge i_clk);
        end while (pending_tris.size() > 0 || start || expected_normals.size() > 0);
        repeat (LAT + 10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_normals.size() == 0) begin
            $display("triangle_unit_normal_tb passed");
        end else begin
            $display("triangle_unit_normal_tb failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/tun_pkg.sv
design/triangle_unit_normal.sv
tb/sv/triangle_unit_normal_tb.sv
